// File: rtl/resonant_four_pole_lowpass_assert.svh
// assertion macros used by the checker of the resonant four-pole lowpass
// no dependencies; the including file supplies clock and reset names
`ifndef RESONANT_FOUR_POLE_LOWPASS_ASSERT_SVH
`define RESONANT_FOUR_POLE_LOWPASS_ASSERT_SVH

// consequent must hold in the cycle after the antecedent, ignored while in reset
`define RFPL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfpl: next-cycle check failed");

// same, but also checked across reset
`define RFPL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rfpl: reset check failed");

`endif

// File: rtl/rfpl_pkg.sv
// shared types and constants of the resonant four-pole lowpass
// no dependencies; used by every rtl module and interface of the block
package rfpl_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 32;

  // configuration port
  localparam int CUTOFF_BITS    = 16;
  localparam int RESONANCE_BITS = 17;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESONANCE = 2'd1;
  localparam int CUTOFF_RESET    = 16384;
  localparam int RESONANCE_RESET = 0;
  localparam int CUTOFF_MAX      = 32768;
  localparam int RESONANCE_MAX   = 65536;

  // coefficient arithmetic, 16 fraction bits
  localparam int COEF_BITS = 17;
  localparam int FB_BITS   = 19;
  localparam int K_BITS    = 18;
  localparam int ONE_Q16   = 65536;
  localparam int K_116     = 76022;
  localparam int K_015     = 9830;
  localparam int K_035013  = 22946;
  localparam int K_03      = 19661;

  // shared multiplier: slices of the signed wide operand times a narrow coefficient
  localparam int MUL_B_BITS     = 20;
  localparam int MUL_CHUNK_BITS = 16;
  localparam int MUL_FRAC_BITS  = 16;

  localparam int POLES          = 4;
  localparam int POLE_IDX_BITS  = 2;
  localparam logic [POLE_IDX_BITS-1:0] POLE_LAST = 2'(POLES - 1);

  typedef enum logic [3:0] {
    OP_F,
    OP_F2,
    OP_F4,
    OP_T,
    OP_FB,
    OP_G,
    OP_FEED,
    OP_GAIN,
    OP_PIN,
    OP_POUT
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                     mul_start;
    op_t                      op;
    logic [POLE_IDX_BITS-1:0] idx;
    logic                     load_sample;
    logic                     load_out;
  } cmd_t;

endpackage

// File: rtl/rfpl_stream_if.sv
// valid/ready stream interfaces for input and output samples
// depends on rfpl_pkg for the default sample width
interface rfpl_in_if #(parameter int SAMPLE_BITS = rfpl_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface rfpl_out_if #(parameter int SAMPLE_BITS = rfpl_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/rfpl_mul.sv
// multi-cycle signed multiplier with rounding by 2^16, one 16-bit slice a cycle
// depends on rfpl_pkg
module rfpl_mul #(
  parameter int A_BITS = rfpl_pkg::STATE_BITS_DEF + 3
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   start,
  input  logic signed [A_BITS-1:0]                               a,
  input  logic signed [rfpl_pkg::MUL_B_BITS-1:0]                 b,
  output logic                                                   done,
  output logic signed [A_BITS+rfpl_pkg::MUL_B_BITS-rfpl_pkg::MUL_FRAC_BITS-1:0] result
);
  localparam int CH  = rfpl_pkg::MUL_CHUNK_BITS;
  localparam int BW  = rfpl_pkg::MUL_B_BITS;
  localparam int FR  = rfpl_pkg::MUL_FRAC_BITS;
  localparam int N   = (A_BITS + CH - 1) / CH;
  localparam int XW  = N * CH;
  localparam int PPW = CH + 1 + BW;
  localparam int PW  = XW + BW;
  localparam int RW  = A_BITS + BW - FR;
  localparam int CW  = (N > 1) ? $clog2(N) : 1;

  logic signed [XW-1:0]  a_sh;
  logic signed [BW-1:0]  b_q;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  pp_valid;
  logic                  pp_last;
  logic signed [PPW:0]   pp;
  logic signed [PW-1:0]  acc;
  logic signed [CH:0]    chunk;
  logic signed [PPW-1:0] mprod;
  logic                  last;

  // top slice carries the sign, lower slices are unsigned
  assign chunk = (cnt == '0) ? {a_sh[XW-1], a_sh[XW-1 -: CH]} : {1'b0, a_sh[XW-1 -: CH]};
  assign mprod = chunk * b_q;
  assign last  = (cnt == CW'(N - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pp_valid <= 1'b0;
      pp_last  <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done     <= pp_valid && pp_last;
      pp_valid <= busy;
      pp_last  <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= XW'(a);
      b_q  <= b;
      acc  <= '0;
    end else begin
      if (busy) begin
        a_sh <= a_sh <<< CH;
        // rounding half is folded into the lowest slice
        pp   <= $signed({mprod[PPW-1], mprod})
              + $signed({{(PPW-FR+1){1'b0}}, last, {(FR-1){1'b0}}});
      end
      if (pp_valid) begin
        acc <= (acc <<< CH) + PW'(pp);
      end
    end
  end

  assign result = acc[FR +: RW];
endmodule

// File: rtl/rfpl_dp.sv
// datapath: config registers, coefficients, pole state, shared multiplier, output register
// depends on rfpl_pkg and rfpl_mul
module rfpl_dp #(
  parameter int SAMPLE_BITS = rfpl_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = rfpl_pkg::STATE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rfpl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rfpl_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  rfpl_pkg::cmd_t                         cmd,
  output logic                                   mul_done,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  output logic signed [SAMPLE_BITS-1:0]          sample_out
);
  localparam int VW  = STATE_BITS + 3;
  localparam int BW  = rfpl_pkg::MUL_B_BITS;
  localparam int MRW = VW + BW - rfpl_pkg::MUL_FRAC_BITS;
  localparam int SH  = STATE_BITS - SAMPLE_BITS - 7;
  localparam int WW  = STATE_BITS + 9;
  localparam int CB  = rfpl_pkg::COEF_BITS;

  localparam logic signed [VW-1:0] ST_MAX = {{(VW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [VW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [WW-1:0] OUT_MAX =
    {{(WW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] OUT_MIN = ~OUT_MAX;

  logic [rfpl_pkg::CUTOFF_BITS-1:0]    cutoff_norm;
  logic [rfpl_pkg::RESONANCE_BITS-1:0] resonance_amount;
  logic [rfpl_pkg::CUTOFF_BITS-1:0]    c_cl;
  logic [rfpl_pkg::RESONANCE_BITS-1:0] r_cl;

  logic [CB-1:0]                    f, f2, f4, t, g;
  logic [rfpl_pkg::FB_BITS-1:0]     fb;
  logic signed [rfpl_pkg::K_BITS-1:0] k;
  logic [CB-1:0]                    one_minus_t;

  logic signed [STATE_BITS-1:0] pin  [rfpl_pkg::POLES];
  logic signed [STATE_BITS-1:0] pout [rfpl_pkg::POLES];
  logic signed [VW-1:0]         v;
  logic signed [VW-1:0]         pin_prod;
  logic signed [SAMPLE_BITS-1:0] smp;

  logic signed [VW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [MRW-1:0] res;
  logic signed [VW-1:0]  res_v;
  logic signed [VW-1:0]  xs;
  logic signed [VW-1:0]  ysum;
  logic signed [STATE_BITS-1:0] ysat;
  logic signed [WW-1:0]  o_wide;

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [VW-1:0] x);
    if (x > ST_MAX) begin
      return ST_MAX[STATE_BITS-1:0];
    end else if (x < ST_MIN) begin
      return ST_MIN[STATE_BITS-1:0];
    end
    return x[STATE_BITS-1:0];
  endfunction

  assign c_cl = (cutoff_norm > rfpl_pkg::CUTOFF_BITS'(rfpl_pkg::CUTOFF_MAX))
              ? rfpl_pkg::CUTOFF_BITS'(rfpl_pkg::CUTOFF_MAX) : cutoff_norm;
  assign r_cl = (resonance_amount > rfpl_pkg::RESONANCE_BITS'(rfpl_pkg::RESONANCE_MAX))
              ? rfpl_pkg::RESONANCE_BITS'(rfpl_pkg::RESONANCE_MAX) : resonance_amount;
  assign one_minus_t = CB'(rfpl_pkg::ONE_Q16) - t;

  // sample into state format
  generate
    if (SH >= 0) begin : g_xs_up
      assign xs = VW'(smp) <<< SH;
    end else begin : g_xs_down
      localparam logic signed [VW-1:0] XS_HALF = VW'(1) <<< (-SH - 1);
      assign xs = (VW'(smp) + XS_HALF) >>> (-SH);
    end
  endgenerate

  // state format back to sample format
  generate
    if (SH > 0) begin : g_o_down
      localparam logic signed [WW-1:0] O_HALF = WW'(1) <<< (SH - 1);
      assign o_wide = (WW'(pout[rfpl_pkg::POLES-1]) + O_HALF) >>> SH;
    end else if (SH == 0) begin : g_o_same
      assign o_wide = WW'(pout[rfpl_pkg::POLES-1]);
    end else begin : g_o_up
      assign o_wide = WW'(pout[rfpl_pkg::POLES-1]) <<< (-SH);
    end
  endgenerate

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      rfpl_pkg::OP_F: begin
        mul_a = VW'($signed({1'b0, c_cl, 1'b0}));
        mul_b = BW'(rfpl_pkg::K_116);
      end
      rfpl_pkg::OP_F2: begin
        mul_a = VW'($signed({1'b0, f}));
        mul_b = BW'($signed({1'b0, f}));
      end
      rfpl_pkg::OP_F4: begin
        mul_a = VW'($signed({1'b0, f2}));
        mul_b = BW'($signed({1'b0, f2}));
      end
      rfpl_pkg::OP_T: begin
        mul_a = VW'($signed({1'b0, f2}));
        mul_b = BW'(rfpl_pkg::K_015);
      end
      rfpl_pkg::OP_FB: begin
        mul_a = VW'($signed({1'b0, r_cl, 2'b00}));
        mul_b = BW'($signed({1'b0, one_minus_t}));
      end
      rfpl_pkg::OP_G: begin
        mul_a = VW'($signed({1'b0, f4}));
        mul_b = BW'(rfpl_pkg::K_035013);
      end
      rfpl_pkg::OP_FEED: begin
        mul_a = VW'(pout[rfpl_pkg::POLES-1]);
        mul_b = BW'($signed({1'b0, fb}));
      end
      rfpl_pkg::OP_GAIN: begin
        mul_a = v;
        mul_b = BW'($signed({1'b0, g}));
      end
      rfpl_pkg::OP_PIN: begin
        mul_a = VW'(pin[cmd.idx]);
        mul_b = BW'(rfpl_pkg::K_03);
      end
      rfpl_pkg::OP_POUT: begin
        mul_a = VW'(pout[cmd.idx]);
        mul_b = BW'(k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rfpl_mul #(.A_BITS(VW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (res)
  );

  assign res_v = res[VW-1:0];
  assign ysum  = v + pin_prod + res_v;
  assign ysat  = sat_state(ysum);

  // config registers and pole state
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_norm      <= rfpl_pkg::CUTOFF_BITS'(rfpl_pkg::CUTOFF_RESET);
      resonance_amount <= rfpl_pkg::RESONANCE_BITS'(rfpl_pkg::RESONANCE_RESET);
      for (int i = 0; i < rfpl_pkg::POLES; i++) begin
        pin[i]  <= '0;
        pout[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfpl_pkg::REG_CUTOFF:    cutoff_norm      <= cfg_data[rfpl_pkg::CUTOFF_BITS-1:0];
          rfpl_pkg::REG_RESONANCE: resonance_amount <= cfg_data[rfpl_pkg::RESONANCE_BITS-1:0];
          default: ;
        endcase
      end
      if (mul_done && cmd.op == rfpl_pkg::OP_POUT) begin
        pin[cmd.idx]  <= v[STATE_BITS-1:0];
        pout[cmd.idx] <= ysat;
      end
    end
  end

  // input sample, output register, coefficients and working values
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      smp <= sample_in;
    end
    if (cmd.load_out) begin
      if (o_wide > OUT_MAX) begin
        sample_out <= OUT_MAX[SAMPLE_BITS-1:0];
      end else if (o_wide < OUT_MIN) begin
        sample_out <= OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
        sample_out <= o_wide[SAMPLE_BITS-1:0];
      end
    end
    if (mul_done) begin
      case (cmd.op)
        rfpl_pkg::OP_F: begin
          f <= res[CB-1:0];
          k <= $signed(rfpl_pkg::K_BITS'(rfpl_pkg::ONE_Q16)) - $signed({1'b0, res[CB-1:0]});
        end
        rfpl_pkg::OP_F2:   f2       <= res[CB-1:0];
        rfpl_pkg::OP_F4:   f4       <= res[CB-1:0];
        rfpl_pkg::OP_T:    t        <= res[CB-1:0];
        rfpl_pkg::OP_FB:   fb       <= res[rfpl_pkg::FB_BITS-1:0];
        rfpl_pkg::OP_G:    g        <= res[CB-1:0];
        rfpl_pkg::OP_FEED: v        <= xs - res_v;
        rfpl_pkg::OP_GAIN: v        <= VW'(sat_state(res_v));
        rfpl_pkg::OP_PIN:  pin_prod <= res_v;
        rfpl_pkg::OP_POUT: v        <= VW'(ysat);
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/rfpl_ctrl.sv
// controller: sequences coefficient, feedback, gain and pole products through the shared multiplier
// depends on rfpl_pkg
module rfpl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           mul_done,
  output rfpl_pkg::cmd_t cmd
);
  rfpl_pkg::state_t                   state, state_next;
  rfpl_pkg::op_t                      op, op_next;
  logic [rfpl_pkg::POLE_IDX_BITS-1:0] idx, idx_next;
  logic                               dirty;
  logic                               out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rfpl_pkg::ST_IDLE:  if (in_valid) state_next = rfpl_pkg::ST_ISSUE;
      rfpl_pkg::ST_ISSUE: state_next = rfpl_pkg::ST_WAIT;
      rfpl_pkg::ST_WAIT: begin
        if (mul_done) begin
          if (op == rfpl_pkg::OP_POUT && idx == rfpl_pkg::POLE_LAST) begin
            state_next = rfpl_pkg::ST_OUT;
          end else begin
            state_next = rfpl_pkg::ST_ISSUE;
          end
        end
      end
      rfpl_pkg::ST_OUT:   if (out_free) state_next = rfpl_pkg::ST_IDLE;
      default:            state_next = rfpl_pkg::ST_IDLE;
    endcase
  end

  // product sequence: coefficients only after reset or a config change
  always_comb begin
    op_next  = op;
    idx_next = idx;
    if (state == rfpl_pkg::ST_IDLE && in_valid) begin
      op_next  = dirty ? rfpl_pkg::OP_F : rfpl_pkg::OP_FEED;
      idx_next = '0;
    end else if (state == rfpl_pkg::ST_WAIT && mul_done) begin
      case (op)
        rfpl_pkg::OP_F:    op_next = rfpl_pkg::OP_F2;
        rfpl_pkg::OP_F2:   op_next = rfpl_pkg::OP_F4;
        rfpl_pkg::OP_F4:   op_next = rfpl_pkg::OP_T;
        rfpl_pkg::OP_T:    op_next = rfpl_pkg::OP_FB;
        rfpl_pkg::OP_FB:   op_next = rfpl_pkg::OP_G;
        rfpl_pkg::OP_G:    op_next = rfpl_pkg::OP_FEED;
        rfpl_pkg::OP_FEED: op_next = rfpl_pkg::OP_GAIN;
        rfpl_pkg::OP_GAIN: op_next = rfpl_pkg::OP_PIN;
        rfpl_pkg::OP_PIN:  op_next = rfpl_pkg::OP_POUT;
        rfpl_pkg::OP_POUT: begin
          op_next  = rfpl_pkg::OP_PIN;
          idx_next = idx + rfpl_pkg::POLE_IDX_BITS'(1);
        end
        default:           op_next = rfpl_pkg::OP_FEED;
      endcase
    end
  end

  // outputs
  always_comb begin
    in_ready        = (state == rfpl_pkg::ST_IDLE);
    cmd.mul_start   = (state == rfpl_pkg::ST_ISSUE);
    cmd.op          = op;
    cmd.idx         = idx;
    cmd.load_sample = (state == rfpl_pkg::ST_IDLE) && in_valid;
    cmd.load_out    = (state == rfpl_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfpl_pkg::ST_IDLE;
      op        <= rfpl_pkg::OP_FEED;
      idx       <= '0;
      dirty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      idx   <= idx_next;
      if (cfg_we) begin
        dirty <= 1'b1;
      end else if (state == rfpl_pkg::ST_WAIT && mul_done && op == rfpl_pkg::OP_G) begin
        dirty <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/resonant_four_pole_lowpass.sv
// Four-pole resonant ladder lowpass, one signed sample in, one filtered sample out.
// Every product goes through one shared multiplier that handles a 16-bit slice of the
// state operand per cycle, and each item needs ten such products (feedback, gain, two
// per pole). After reset or any configuration write the next item first recomputes the
// cutoff and resonance coefficients, six more products. A finished sample waits in the
// output register while the next input is taken. Write configuration only while the
// block is idle.
module resonant_four_pole_lowpass #(
  parameter int SAMPLE_BITS = rfpl_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = rfpl_pkg::STATE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rfpl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rfpl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  rfpl_in_if.sink                             rx,
  rfpl_out_if.source                          tx
);
  rfpl_pkg::cmd_t                cmd;
  logic                          mul_done;
  logic                          in_ready;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  rfpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (rx.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (tx.ready),
    .mul_done  (mul_done),
    .cmd       (cmd)
  );

  rfpl_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .mul_done   (mul_done),
    .sample_in  (rx.sample_in),
    .sample_out (sample_out)
  );

  assign rx.ready      = in_ready;
  assign tx.valid      = out_valid;
  assign tx.sample_out = sample_out;
endmodule

// File: rtl/rfpl_checker.sv
// port-level checks for the resonant four-pole lowpass, bound to the top level
// depends on resonant_four_pole_lowpass_assert.svh and the top level
`include "resonant_four_pole_lowpass_assert.svh"

module rfpl_checker #(
  parameter int SAMPLE_BITS = rfpl_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out
);
  // one item in flight: input side closes right after a beat
  `RFPL_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  // a result never shows up the cycle after a new beat is taken
  `RFPL_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))
  `RFPL_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `RFPL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_out))
endmodule

bind resonant_four_pole_lowpass rfpl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rfpl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (rx.valid),
  .in_ready   (rx.ready),
  .out_valid  (tx.valid),
  .out_ready  (tx.ready),
  .sample_out (tx.sample_out)
);

// File: dv/tb_resonant_four_pole_lowpass.sv
// testbench of the resonant four-pole lowpass: a directed table, then random phases of
// audio-like streams, each beat checked against a fixed-point predictor or a typed value
// depends on rfpl_pkg, the rfpl stream interfaces and the resonant_four_pole_lowpass top
module tb_resonant_four_pole_lowpass;
  import rfpl_pkg::*;

  localparam int SMP_W = SAMPLE_BITS_DEF;

  // indexes past the two registers, writes there must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  // ladder coefficients in q16, applied to the q15 cutoff
  localparam longint Q16_ONE     = 65536;
  localparam longint C_CUT_SCALE = 76022;
  localparam longint C_FB_TRIM   = 9830;
  localparam longint C_GAIN      = 22946;
  localparam longint C_PREV_TAP  = 19661;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;
  typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_RAIL, WAVE_QUIET} wave_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [SMP_W-1:0]          smp;
    logic                      typed;
    logic [SMP_W-1:0]          typed_out;
  } plan_row_t;

  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // zero cutoff kills the gain, so rails come out as zero
    '{ROW_REG,    REG_CUTOFF,    17'd0,       16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b1, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'h8000,       1'b1, 16'd0},
    '{ROW_REG,    REG_RESONANCE, 17'd65536,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b1, 16'd0},
    // cutoff at one, full feedback
    '{ROW_REG,    REG_CUTOFF,    17'd32768,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'h8000,       1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'h8000,       1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'd0,          1'b0, 16'd0},
    // resonance above four
    '{ROW_REG,    REG_RESONANCE, 17'h1FFFF,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'h8000,       1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b0, 16'd0},
    // cutoff above one
    '{ROW_REG,    REG_CUTOFF,    17'd65535,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'h8000,       1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd32767,     1'b0, 16'd0},
    // bit 16 does not belong to the cutoff register
    '{ROW_REG,    REG_CUTOFF,    17'h12000,   16'd0,          1'b0, 16'd0},
    '{ROW_REG,    REG_SPARE_2,   17'h1FFFF,   16'd0,          1'b0, 16'd0},
    '{ROW_REG,    REG_SPARE_3,   17'h04000,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd1,         1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       -16'sd1,        1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd16384,     1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       -16'sd16385,    1'b0, 16'd0},
    '{ROW_REG,    REG_RESONANCE, 17'd65537,   16'd0,          1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       16'sd12345,     1'b0, 16'd0},
    '{ROW_SAMPLE, REG_CUTOFF,    17'd0,       -16'sd20000,    1'b0, 16'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  rfpl_in_if  rx ();
  rfpl_out_if tx ();

  resonant_four_pole_lowpass DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .tx        (tx)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and ladder state
  logic [CUTOFF_BITS-1:0]    cut_reg;
  logic [RESONANCE_BITS-1:0] res_reg;
  longint                    stage_in [4];
  longint                    stage_out [4];

  logic [SMP_W-1:0] pending_out [$];
  logic             lit_on;
  logic [SMP_W-1:0] lit_val;
  bit               steady = 1'b0;
  int               mismatches = 0;
  int               samples_in = 0;
  int               samples_out = 0;
  int               reg_writes = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, 16);
  endfunction

  // one sample through the ladder, updates the predictor state
  function automatic logic [SMP_W-1:0] filter_sample(logic [SMP_W-1:0] s);
    longint c, r, f, f2, f4, fb, g, k, v, y;
    c = (cut_reg > CUTOFF_MAX) ? CUTOFF_MAX : longint'(cut_reg);
    r = (res_reg > RESONANCE_MAX) ? RESONANCE_MAX : longint'(res_reg);
    f  = round_shift(c * C_CUT_SCALE, 15);
    f2 = round_shift(f * f, 16);
    f4 = round_shift(f2 * f2, 16);
    fb = round_shift(r * (Q16_ONE - round_shift(C_FB_TRIM * f2, 16)), 14);
    g  = round_shift(C_GAIN * f4, 16);
    k  = Q16_ONE - f;
    // q1.15 into q8.24
    v = longint'($signed(s)) * 512;
    v = clip(qmul(v - qmul(stage_out[3], fb), g), 32);
    for (int i = 0; i < 4; i++) begin
      y = clip(v + qmul(stage_in[i], C_PREV_TAP) + qmul(stage_out[i], k), 32);
      stage_in[i]  = v;
      stage_out[i] = y;
      v = y;
    end
    return SMP_W'(clip(round_shift(stage_out[3], 9), SMP_W));
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  always @(posedge clk) begin : watch
    logic [SMP_W-1:0] want;
    if (rst) begin
      cut_reg = CUTOFF_RESET;
      res_reg = RESONANCE_RESET;
      for (int i = 0; i < 4; i++) begin
        stage_in[i]  = 0;
        stage_out[i] = 0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CUTOFF:    cut_reg = cfg_data[CUTOFF_BITS-1:0];
          REG_RESONANCE: res_reg = cfg_data[RESONANCE_BITS-1:0];
          default: ;
        endcase
      end
      if (tx.valid && tx.ready) begin
        samples_out++;
        if (pending_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: output beat with nothing expected, got %0d", $time,
                     $signed(tx.sample_out));
        end else begin
          want = pending_out.pop_front();
          if (tx.sample_out !== want) begin
            mismatches++;
            if (mismatches <= 40)
              $display("%0t: sample_out expected %0d, got %0d", $time, $signed(want),
                       $signed(tx.sample_out));
          end
        end
      end
      if (rx.valid && rx.ready) begin
        want = filter_sample(rx.sample_in);
        pending_out.push_back(lit_on ? lit_val : want);
        samples_in++;
      end
    end
  end

  // output side back-pressure
  initial begin : out_pacing
    int stall;
    stall = 0;
    tx.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        tx.ready <= 1'b0;
        stall--;
      end else begin
        tx.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall = idle_len();
      end
    end
  end

  // valid is left high after a beat; the next call either keeps it up or drops it
  task automatic send_sample(input logic [SMP_W-1:0] s, input logic typed,
                             input logic [SMP_W-1:0] typed_out);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid     <= 1'b1;
    rx.sample_in <= s;
    lit_on       <= typed;
    lit_val      <= typed_out;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding beat, plus a short margin
  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  initial begin : stimulus
    wave_e                    mode;
    int                       run_left;
    int                       amp;
    int                       period;
    int                       tick;
    logic [SMP_W-1:0]         s;
    logic [CFG_DATA_BITS-1:0] cd;
    logic [CFG_DATA_BITS-1:0] rd;
    run_left = 0;
    mode = WAVE_NOISE;
    amp = 0;
    period = 1;
    tick = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx.valid = 1'b0;
    rx.sample_in = '0;
    lit_on = 1'b0;
    lit_val = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int j = 0; j < PLAN_ROWS; j++) begin
      if (PLAN[j].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[j].idx, PLAN[j].data);
      end else begin
        send_sample(PLAN[j].smp, PLAN[j].typed, PLAN[j].typed_out);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin
          cd = CFG_DATA_BITS'(CUTOFF_MAX);
          rd = CFG_DATA_BITS'(RESONANCE_MAX);
        end
        1: begin
          cd = 17'd1;
          rd = '0;
        end
        2: begin
          cd = 17'h1FFFF;
          rd = 17'h1FFFF;
        end
        default: begin
          cd = CFG_DATA_BITS'($urandom_range(0, CUTOFF_MAX));
          cd[16] = $urandom_range(0, 1);
          rd = CFG_DATA_BITS'($urandom_range(0, RESONANCE_MAX + 4096));
        end
      endcase
      write_reg(REG_CUTOFF, cd);
      write_reg(REG_RESONANCE, rd);
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_BITS'($urandom));
      steady = (ph % 3 == 1);
      for (int n = 0; n < 100; n++) begin
        // runs of one waveform so the resonance can build up
        if (run_left == 0) begin
          mode = wave_e'($urandom_range(0, 3));
          run_left = $urandom_range(4, 40);
          amp = $urandom_range(0, 32767);
          period = $urandom_range(1, 12);
          tick = 0;
        end
        case (mode)
          WAVE_NOISE:  s = SMP_W'($urandom);
          WAVE_SQUARE: s = ((tick / period) % 2 != 0) ? SMP_W'(-amp - 1) : SMP_W'(amp);
          WAVE_RAIL:   s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default:     s = SMP_W'($urandom_range(0, 511) - 256);
        endcase
        tick++;
        run_left--;
        send_sample(s, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d samples in, %0d out, %0d register writes", samples_in,
             samples_out, reg_writes);
    $display("zero and full cutoff, resonance past four, wide and unused writes, 7 phases");
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("resonant_four_pole_lowpass: match");
    end else begin
      $display("resonant_four_pole_lowpass: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("resonant_four_pole_lowpass: mismatch");
    $finish;
  end

endmodule
